@@ design/bary_pkg.sv @@
// ----------------------------------------------------------------------------
// bary_pkg
// Shared types and constants for the barycentric coordinate pipeline.
// ----------------------------------------------------------------------------
package bary_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int OUT_FRAC_BITS_DEF = 16;
  localparam int FIELD_W           = 16;
  localparam int WEIGHT_W          = 32;
  localparam int THR_W             = 10;
  localparam logic [THR_W-1:0] THR_RESET = 10'd2;
  // quotient bits kept before saturation; enough for 1 - q to saturate right
  localparam int QUOT_BITS         = 33;

  typedef struct packed {
    logic signed [FIELD_W-1:0] ax;
    logic signed [FIELD_W-1:0] ay;
    logic signed [FIELD_W-1:0] bx;
    logic signed [FIELD_W-1:0] by_coord;
    logic signed [FIELD_W-1:0] cx;
    logic signed [FIELD_W-1:0] cy;
    logic signed [FIELD_W-1:0] px;
    logic signed [FIELD_W-1:0] py;
  } in_item_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_a;
    logic signed [WEIGHT_W-1:0] weight_b;
    logic signed [WEIGHT_W-1:0] weight_c;
    logic                       degenerate;
    logic                       inside_res;
  } out_item_t;

  typedef struct packed {
    logic degen;
    logic neg_a;
    logic neg_b;
    logic neg_c;
  } div_flags_t;

endpackage

@@ design/bary_front.sv @@
// ----------------------------------------------------------------------------
// bary_front
// Edge vectors, cross product, magnitudes and degenerate test (5 stages).
// ----------------------------------------------------------------------------
module bary_front #(
  parameter int COORD_WIDTH = bary_pkg::COORD_WIDTH_DEF,
  parameter int MAG_W       = 2 * (COORD_WIDTH + 1) + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  bary_pkg::in_item_t            item_i,
  input  logic [bary_pkg::THR_W-1:0]    thr_i,
  output logic                          vld_o,
  output bary_pkg::div_flags_t          flags_o,
  output logic [MAG_W-1:0]              d_o,
  output logic [MAG_W-1:0]              na_o,
  output logic [MAG_W-1:0]              nb_o,
  output logic [MAG_W-1:0]              nc_o
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int UW = PW + 1;
  localparam int SW = UW + 1;

  logic signed [CW-1:0] ax_c, ay_c, bx_c, by_c, cx_c, cy_c, px_c, py_c;

  assign ax_c = CW'(item_i.ax);
  assign ay_c = CW'(item_i.ay);
  assign bx_c = CW'(item_i.bx);
  assign by_c = CW'(item_i.by_coord);
  assign cx_c = CW'(item_i.cx);
  assign cy_c = CW'(item_i.cy);
  assign px_c = CW'(item_i.px);
  assign py_c = CW'(item_i.py);

  logic [4:0] vld_r;

  // stage 1: edge vectors
  logic signed [DW-1:0] s0x_r, s0y_r, s0z_r, s1x_r, s1y_r, s1z_r;
  // stage 2: products
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [PW-1:0] p0_nxt, p1_nxt, p2_nxt, p3_nxt, p4_nxt, p5_nxt;
  // stage 3: cross product
  logic signed [UW-1:0] ux_r, uy_r, uz_r;
  // stage 4: sum and magnitudes
  logic signed [SW-1:0] sum_r;
  logic [UW-1:0]        uxa_r, uya_r, uza_r;
  logic                 uxn_r, uyn_r, uzn_r;
  logic [SW-1:0]        suma_nxt;

  always_comb begin
    p0_nxt = s0y_r * s1z_r;
    p1_nxt = s0z_r * s1y_r;
    p2_nxt = s0z_r * s1x_r;
    p3_nxt = s0x_r * s1z_r;
    p4_nxt = s0x_r * s1y_r;
    p5_nxt = s0y_r * s1x_r;
    suma_nxt = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0x_r <= DW'(cx_c) - DW'(ax_c);
      s0y_r <= DW'(bx_c) - DW'(ax_c);
      s0z_r <= DW'(ax_c) - DW'(px_c);
      s1x_r <= DW'(cy_c) - DW'(ay_c);
      s1y_r <= DW'(by_c) - DW'(ay_c);
      s1z_r <= DW'(ay_c) - DW'(py_c);

      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      p3_r <= p3_nxt;
      p4_r <= p4_nxt;
      p5_r <= p5_nxt;

      ux_r <= UW'(p0_r) - UW'(p1_r);
      uy_r <= UW'(p2_r) - UW'(p3_r);
      uz_r <= UW'(p4_r) - UW'(p5_r);

      sum_r <= SW'(ux_r) + SW'(uy_r);
      uxa_r <= ux_r[UW-1] ? UW'(-ux_r) : UW'(ux_r);
      uya_r <= uy_r[UW-1] ? UW'(-uy_r) : UW'(uy_r);
      uza_r <= uz_r[UW-1] ? UW'(-uz_r) : UW'(uz_r);
      uxn_r <= ux_r[UW-1];
      uyn_r <= uy_r[UW-1];
      uzn_r <= uz_r[UW-1];

      na_o <= MAG_W'(suma_nxt);
      nb_o <= MAG_W'(uya_r);
      nc_o <= MAG_W'(uxa_r);
      d_o  <= MAG_W'(uza_r);
      flags_o.degen <= !(uza_r > UW'(thr_i));
      flags_o.neg_a <= sum_r[SW-1] ^ uzn_r;
      flags_o.neg_b <= uyn_r ^ uzn_r;
      flags_o.neg_c <= uxn_r ^ uzn_r;
    end
  end

  assign vld_o = vld_r[4];

endmodule

@@ design/bary_div_step.sv @@
// ----------------------------------------------------------------------------
// bary_div_step
// One restoring division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
module bary_div_step #(
  parameter int MAG_W = 36
) (
  input  logic [MAG_W-1:0] rem_i,
  input  logic [MAG_W-1:0] d_i,
  input  logic             bit_i,
  output logic [MAG_W-1:0] rem_o,
  output logic             q_o
);

  logic [MAG_W:0] trial;

  always_comb begin
    trial = {rem_i, bit_i};
    q_o   = trial >= {1'b0, d_i};
    rem_o = q_o ? MAG_W'(trial - {1'b0, d_i}) : MAG_W'(trial);
  end

endmodule

@@ design/bary_div.sv @@
// ----------------------------------------------------------------------------
// bary_div
// Pipelined three-lane fixed-point divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bary_div #(
  parameter int MAG_W         = 36,
  parameter int OUT_FRAC_BITS = bary_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  vld_i,
  input  bary_pkg::div_flags_t                  flags_i,
  input  logic [MAG_W-1:0]                      d_i,
  input  logic [2:0][MAG_W-1:0]                 n_i,
  output logic                                  vld_o,
  output bary_pkg::div_flags_t                  flags_o,
  output logic [2:0]                            ovf_o,
  output logic [2:0][bary_pkg::QUOT_BITS-1:0]   q_o
);

  localparam int QB = bary_pkg::QUOT_BITS;
  localparam int F  = OUT_FRAC_BITS;
  localparam int SH = QB - F;

  logic                       vld_r   [QB+1];
  bary_pkg::div_flags_t       flags_r [QB+1];
  logic [2:0]                 ovf_r   [QB+1];
  logic [MAG_W-1:0]           d_r     [QB+1];
  logic [2:0][MAG_W-1:0]      n_r     [QB+1];
  logic [2:0][MAG_W-1:0]      rem_r   [QB+1];
  logic [2:0][QB-1:0]         q_r     [QB+1];

  logic [MAG_W+SH-1:0] d_sh;
  assign d_sh = {d_i, SH'(0)};

  // entry stage: overflow test and starting remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r[0] <= flags_i;
      d_r[0]     <= d_i;
      n_r[0]     <= n_i;
      q_r[0]     <= '0;
      for (int l = 0; l < 3; l++) begin
        ovf_r[0][l] <= (MAG_W+SH)'(n_i[l]) >= d_sh;
        rem_r[0][l] <= n_i[l] >> SH;
      end
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int J = QB - 1 - k;
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic             bit_in;
      logic [MAG_W-1:0] rem_nxt;
      logic             q_bit;

      if (J >= F) begin : g_nbit
        assign bit_in = n_r[k][l][J-F];
      end else begin : g_zero
        assign bit_in = 1'b0;
      end

      bary_div_step #(.MAG_W(MAG_W)) u_step (
        .rem_i (rem_r[k][l]),
        .d_i   (d_r[k]),
        .bit_i (bit_in),
        .rem_o (rem_nxt),
        .q_o   (q_bit)
      );

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1][l] <= rem_nxt;
          q_r[k+1][l]   <= {q_r[k][l][QB-2:0], q_bit};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        flags_r[k+1] <= flags_r[k];
        ovf_r[k+1]   <= ovf_r[k];
        d_r[k+1]     <= d_r[k];
        n_r[k+1]     <= n_r[k];
      end
    end
  end

  assign vld_o   = vld_r[QB];
  assign flags_o = flags_r[QB];
  assign ovf_o   = ovf_r[QB];
  assign q_o     = q_r[QB];

endmodule

@@ design/barycentric_coordinates.sv @@
// ----------------------------------------------------------------------------
// barycentric_coordinates
// Barycentric weights of a point against a 2D triangle, fixed-point.
// ----------------------------------------------------------------------------
// channel   direction  payload               handshake
// in_       input      bary_pkg::in_item_t   in_valid / in_stall
// out_      output     bary_pkg::out_item_t  out_valid / out_stall
// cfg_      input      degenerate threshold  cfg_we / cfg_wdata
//
// one item per cycle sustained while the output is not stalled; 5 front
// stages, 1 divider entry stage, one stage per quotient bit, 1 output stage
// the 33-bit restoring divider sets the depth
// reset clears all valid bits and loads the threshold with 2
// a stalled output holding a valid result freezes the whole pipeline and stalls the input
// ----------------------------------------------------------------------------
module barycentric_coordinates #(
  parameter int COORD_WIDTH   = bary_pkg::COORD_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = bary_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bary_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bary_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [bary_pkg::THR_W-1:0]  cfg_wdata
);

  localparam int MAG_W = 2 * (COORD_WIDTH + 1) + 2;
  localparam int QB    = bary_pkg::QUOT_BITS;
  localparam int WW    = bary_pkg::WEIGHT_W;
  localparam int F     = OUT_FRAC_BITS;
  localparam int VW    = QB + 3;

  localparam logic signed [WW-1:0] ONE     = WW'(1) << F;
  localparam logic signed [VW-1:0] ONE_V   = VW'(1) << F;
  localparam logic signed [VW-1:0] W_MAX_V = VW'({1'b0, {(WW-1){1'b1}}});
  localparam logic signed [VW-1:0] W_MIN_V = -W_MAX_V - VW'(1);

  logic                         en;
  logic [bary_pkg::THR_W-1:0]   thr_r;
  logic                         out_valid_r;
  bary_pkg::out_item_t          out_item_r;
  bary_pkg::out_item_t          out_item_nxt;

  logic                         f_vld;
  bary_pkg::div_flags_t         f_flags;
  logic [MAG_W-1:0]             f_d;
  logic [2:0][MAG_W-1:0]        f_n;

  logic                         q_vld;
  bary_pkg::div_flags_t         q_flags;
  logic [2:0]                   q_ovf;
  logic [2:0][QB-1:0]           q_mag;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= bary_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  bary_front #(.COORD_WIDTH(COORD_WIDTH), .MAG_W(MAG_W)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_valid),
    .item_i  (in_item),
    .thr_i   (thr_r),
    .vld_o   (f_vld),
    .flags_o (f_flags),
    .d_o     (f_d),
    .na_o    (f_n[0]),
    .nb_o    (f_n[1]),
    .nc_o    (f_n[2])
  );

  bary_div #(.MAG_W(MAG_W), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (f_vld),
    .flags_i (f_flags),
    .d_i     (f_d),
    .n_i     (f_n),
    .vld_o   (q_vld),
    .flags_o (q_flags),
    .ovf_o   (q_ovf),
    .q_o     (q_mag)
  );

  // signed quotients, then 1 - q for A, then saturate
  logic [2:0]                  q_neg;
  logic [QB:0]                 mag  [3];
  logic signed [VW-1:0]        sq   [3];
  logic signed [VW-1:0]        wv   [3];
  logic signed [WW-1:0]        wsat [3];

  assign q_neg = {q_flags.neg_c, q_flags.neg_b, q_flags.neg_a};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = q_ovf[l] ? (QB+1)'(1) << QB : {1'b0, q_mag[l]};
      sq[l]  = q_neg[l] ? -VW'(mag[l]) : VW'(mag[l]);
    end
    wv[0] = ONE_V - sq[0];
    wv[1] = sq[1];
    wv[2] = sq[2];
    for (int l = 0; l < 3; l++) begin
      if (wv[l] > W_MAX_V) begin
        wsat[l] = W_MAX_V[WW-1:0];
      end else if (wv[l] < W_MIN_V) begin
        wsat[l] = W_MIN_V[WW-1:0];
      end else begin
        wsat[l] = wv[l][WW-1:0];
      end
    end
    if (q_flags.degen) begin
      out_item_nxt.weight_a = -ONE;
      out_item_nxt.weight_b = ONE;
      out_item_nxt.weight_c = ONE;
    end else begin
      out_item_nxt.weight_a = wsat[0];
      out_item_nxt.weight_b = wsat[1];
      out_item_nxt.weight_c = wsat[2];
    end
    out_item_nxt.degenerate = q_flags.degen;
    out_item_nxt.inside_res = !out_item_nxt.weight_a[WW-1] &&
                              !out_item_nxt.weight_b[WW-1] &&
                              !out_item_nxt.weight_c[WW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_degen_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.degenerate) |-> !out_item.inside_res)
    else $error("degenerate item flagged inside");

  a_degen_weights: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.degenerate) |->
      (out_item.weight_b == ONE && out_item.weight_c == ONE &&
       out_item.weight_a == -ONE))
    else $error("degenerate item with wrong weights");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

@@ tb/barycentric_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barycentric_checker
// Watches the item and result channels of the barycentric coordinate block,
// tracks the degenerate threshold from the register port, works out the
// weights of every accepted item and compares each result in order.
// ----------------------------------------------------------------------------
module barycentric_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  bary_pkg::in_item_t         in_item,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  bary_pkg::out_item_t        out_item,
  input  logic                       cfg_we,
  input  logic [bary_pkg::THR_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         weights_pending
);

  localparam int       FRAC = bary_pkg::OUT_FRAC_BITS_DEF;
  localparam longint   ONE  = 64'sd1 << FRAC;

  logic [bary_pkg::THR_W-1:0] thr;
  bary_pkg::out_item_t        weights_due[$];

  // trunc(num * 2^FRAC / den) toward zero, magnitude clamped at 2^40
  function automatic longint fixed_quot(longint num, longint den);
    longint n, d, mag;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    if (d == 0) return 0;
    if (n / d >= (64'sd1 << (40 - FRAC))) mag = 64'sd1 << 40;
    else mag = (n << FRAC) / d;
    return ((num < 0) != (den < 0)) ? -mag : mag;
  endfunction

  function automatic logic signed [bary_pkg::WEIGHT_W-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[bary_pkg::WEIGHT_W-1:0];
  endfunction

  function automatic bary_pkg::out_item_t bary_weights(bary_pkg::in_item_t it,
                                                       logic [bary_pkg::THR_W-1:0] t);
    bary_pkg::out_item_t r;
    longint    s0x, s0y, s0z, s1x, s1y, s1z, ux, uy, uz, uz_mag;
    s0x = longint'(it.cx) - longint'(it.ax);
    s0y = longint'(it.bx) - longint'(it.ax);
    s0z = longint'(it.ax) - longint'(it.px);
    s1x = longint'(it.cy) - longint'(it.ay);
    s1y = longint'(it.by_coord) - longint'(it.ay);
    s1z = longint'(it.ay) - longint'(it.py);
    ux = s0y * s1z - s0z * s1y;
    uy = s0z * s1x - s0x * s1z;
    uz = s0x * s1y - s0y * s1x;
    uz_mag = (uz < 0) ? -uz : uz;
    if (uz_mag > longint'(t)) begin
      r.weight_a   = clamp32(ONE - fixed_quot(ux + uy, uz));
      r.weight_b   = clamp32(fixed_quot(uy, uz));
      r.weight_c   = clamp32(fixed_quot(ux, uz));
      r.degenerate = 1'b0;
    end else begin
      r.weight_a   = clamp32(-ONE);
      r.weight_b   = clamp32(ONE);
      r.weight_c   = clamp32(ONE);
      r.degenerate = 1'b1;
    end
    r.inside_res = (r.weight_a >= 0) && (r.weight_b >= 0) && (r.weight_c >= 0);
    return r;
  endfunction

  assign weights_pending = weights_due.size();

  always @(posedge clk) begin
    bary_pkg::out_item_t want;
    if (!rst_n) begin
      thr        <= bary_pkg::THR_RESET;
      fail_count <= 0;
      weights_due.delete();
    end else begin
      if (cfg_we) thr <= cfg_wdata;
      if (in_valid && !in_stall) weights_due.push_back(bary_weights(in_item, thr));
      if (out_valid && !out_stall) begin
        if (weights_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %p", out_item);
        end else begin
          want = weights_due.pop_front();
          if (want !== out_item) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("weights differ: expected %p got %p", want, out_item);
          end
        end
      end
    end
  end

endmodule

@@ tb/tb_barycentric_coordinates.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barycentric_coordinates
// Drives triangles and query points into the barycentric block under random
// gaps and output stalls, across several degenerate thresholds; the checker
// beside the block predicts and compares the weights.
// ----------------------------------------------------------------------------
module tb_barycentric_coordinates;

  localparam int CYCLE_LIMIT = 500000;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  bary_pkg::in_item_t         in_item = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  bary_pkg::out_item_t        out_item;
  logic                       cfg_we = 1'b0;
  logic [bary_pkg::THR_W-1:0] cfg_wdata = '0;
  int                         fail_count;
  int                         weights_pending;
  int                         cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  barycentric_coordinates u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  barycentric_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .weights_pending (weights_pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int roll;
    roll = int'($urandom_range(99));
    if (roll < 55) return 0;
    if (roll < 95) return int'($urandom_range(3, 1));
    return int'($urandom_range(60, 15));
  endfunction

  // output stall: calm stretches alternate with busy ones
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(80, 20)) @(negedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          @(negedge clk) out_stall <= 1'b1;
          repeat (n - 1) @(negedge clk);
          @(negedge clk) out_stall <= 1'b0;
        end else begin
          @(negedge clk);
        end
      end
    end
  end

  task automatic send_item(bary_pkg::in_item_t it);
    int g;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    g = gap_len();
    if (g > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // stop offering items, then wait for every result
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (weights_pending != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_threshold(logic [bary_pkg::THR_W-1:0] v);
    drain();
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  function automatic bary_pkg::in_item_t pt8(int ax, int ay, int bx, int by, int cx,
                                             int cy, int px, int py);
    bary_pkg::in_item_t it;
    it.ax = 16'(ax); it.ay = 16'(ay); it.bx = 16'(bx); it.by_coord = 16'(by);
    it.cx = 16'(cx); it.cy = 16'(cy); it.px = 16'(px); it.py = 16'(py);
    return it;
  endfunction

  function automatic int rnd_in(int lo, int hi);
    return int'($urandom_range(hi - lo)) + lo;
  endfunction

  // full-range noise, well-formed triangles with nearby points, near-collinear
  function automatic bary_pkg::in_item_t rand_item();
    bary_pkg::in_item_t it;
    int       roll, span, ox, oy;
    roll = int'($urandom_range(99));
    if (roll < 25) begin
      it = bary_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    end else if (roll < 75) begin
      span = ($urandom_range(3) == 0) ? 8000 : 400;
      ox = rnd_in(-20000, 20000);
      oy = rnd_in(-20000, 20000);
      it = pt8(ox + rnd_in(-span, span), oy + rnd_in(-span, span),
               ox + rnd_in(-span, span), oy + rnd_in(-span, span),
               ox + rnd_in(-span, span), oy + rnd_in(-span, span),
               ox + rnd_in(-span, span), oy + rnd_in(-span, span));
    end else begin
      ox = rnd_in(-30000, 30000);
      oy = rnd_in(-30000, 30000);
      it = pt8(ox, oy, ox + rnd_in(-6, 6), oy + rnd_in(-6, 6),
               ox + rnd_in(-6, 6), oy + rnd_in(-6, 6),
               rnd_in(-32768, 32767), rnd_in(-32768, 32767));
    end
    return it;
  endfunction

  initial begin
    logic [bary_pkg::THR_W-1:0] phase_thr[5];
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: reset threshold of 2
    send_item('0);
    send_item(pt8(0, 0, 16, 0, 0, 16, 4, 4));
    send_item(pt8(0, 0, 16, 0, 0, 16, 16, 16));
    send_item(pt8(0, 0, 0, 16, 16, 0, 4, 4));
    send_item(pt8(0, 0, 1, 0, 0, 1, 0, 0));
    send_item(pt8(0, 0, 1, 0, 0, 2, 0, 0));
    send_item(pt8(0, 0, 1, 0, 0, 3, 0, 0));
    send_item(pt8(0, 0, 2, 0, 0, 2, 1, 1));
    send_item(pt8(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
    send_item(pt8(-32768, -32768, 32767, -32768, -32768, 32767,
                  32767, 32767));
    send_item(pt8(32767, 32767, -32768, 32767, 32767, -32768,
                  -32768, -32768));
    send_item(pt8(0, 0, 1, 0, 0, 3, 32767, -32768));
    send_item(pt8(0, 0, 1, 0, 0, 3, -32768, 32767));
    send_item(pt8(0, 0, 3, 1, 1, 0, -32768, -32768));
    send_item(pt8(10, 10, 20, 20, 30, 30, 5, 5));
    send_item(pt8(-32768, 0, 32767, 0, 0, 1, 0, 0));
    send_item(pt8(0, 0, 16, 0, 0, 16, 0, 0));
    send_item(pt8(0, 0, 16, 0, 0, 16, 16, 0));
    send_item(pt8(0, 0, 16, 0, 0, 16, -1, 8));
    send_item('1);
    send_item(pt8(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));

    // pause the sender until the pipeline is empty
    drain();

    phase_thr[0] = 10'd0;
    phase_thr[1] = 10'd1023;
    phase_thr[2] = 10'($urandom_range(1022, 1));
    phase_thr[3] = 10'd2;
    phase_thr[4] = 10'($urandom_range(1023));
    foreach (phase_thr[p]) begin
      write_threshold(phase_thr[p]);
      send_item(pt8(0, 0, 1, 0, 0, 1, 0, 0));
      repeat (125) send_item(rand_item());
    end

    @(negedge clk) in_valid <= 1'b0;
    drain();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
